FILE: hw/rtl/mws_pkg.sv
// Package for the multi-waveform shaper: opcodes, sizes, LFSR taps and the sine quarter table.
`timescale 1ns / 1ps

package mws_pkg;

   // Waveform selector codes
   typedef enum logic [2:0] {
      OP_SINE     = 3'd0,
      OP_SQUARE   = 3'd1,
      OP_SAWTOOTH = 3'd2,
      OP_TRIANGLE = 3'd3,
      OP_NOISE    = 3'd4
   } op_type;

   localparam int PHASE_BITS     = 16;
   localparam int SAMPLE_BITS    = 16;
   localparam int LFSR_BITS      = 32;
   localparam int SINE_ADDR_BITS = 10;
   localparam int QBITS          = SINE_ADDR_BITS - 2;
   localparam int QSIZE          = 1 << QBITS;

   localparam logic [LFSR_BITS-1:0]   LFSR_TAPS   = 32'hD000_0001;
   localparam logic [LFSR_BITS-1:0]   LFSR_RESET  = 32'h0000_0001;
   localparam logic [SAMPLE_BITS-1:0] FULL_POS    = 16'h7FFF;
   localparam logic [SAMPLE_BITS-1:0] FULL_NEG    = 16'h8000;
   localparam logic [63:0]            HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

   typedef logic [SAMPLE_BITS-1:0] sine_table_type [QSIZE];

   // (a * b) >> 62, truncated to 64 bits
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // unsigned 64-bit quotient by restoring long division, used only at elaboration
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // round(32767 * sin(pi/2 * i / QSIZE)) for i below QSIZE, worked out at elaboration
   // with a Q62 Taylor series; the top entry (i = QSIZE) is full scale and handled apart
   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    term;
      logic [63:0]    sum;
      logic [63:0]    scaled;
      logic [63:0]    divisor;
      logic           subtract;
      for (int i = 0; i < QSIZE; i++) begin
         x = (HALF_PI_Q62 >> QBITS) * 64'(i)
             + (((HALF_PI_Q62 & 64'(QSIZE - 1)) * 64'(i)) >> QBITS);
         x2       = mul_q62(x, x);
         term     = x;
         sum      = x;
         subtract = 1'b1;
         for (int k = 1; k < 60; k++) begin
            if (term != 64'd0) begin
               divisor = 64'((2 * k) * (2 * k + 1));
               term    = udiv64(mul_q62(term, x2), divisor);
               sum     = subtract ? (sum - term) : (sum + term);
               subtract = !subtract;
            end
         end
         scaled = (((sum >> 20) * 64'd32767) + (64'd1 << 41)) >> 42;
         tbl[i] = scaled[SAMPLE_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_QUARTER = build_sine_table();

endpackage

FILE: hw/rtl/multi_waveform_shaper.sv
// Top level of the multi-waveform shaper: request register, waveform logic, response register.
`timescale 1ns / 1ps

// multi_waveform_shaper turns a waveform selector and a 16-bit phase (65536 = one turn) into
// one signed Q1.15 sample: sine, square, sawtooth, triangle or LFSR noise; selectors 5 to 7
// give sine. It takes one request per clock and returns one response per clock. A request
// passes through the request register and then the response register, with all waveform
// logic and the sine quarter-table lookup between them. Both stages stall together when
// the response is not taken. A write on the csr_ port loads the
// noise shift register at once (a zero seed loads 1); write it only while no request is in
// flight. The noise register steps once for every noise request, in request order.
module multi_waveform_shaper (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [2:0]                             req_op,
   input  logic [mws_pkg::PHASE_BITS-1:0]         req_phase,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [mws_pkg::SAMPLE_BITS-1:0] rsp_sample,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mws_pkg::LFSR_BITS-1:0]          csr_noise_seed
);
   import mws_pkg::*;

   // request stage
   logic                   s1_valid_ff;
   logic [2:0]             s1_op_ff;
   logic [PHASE_BITS-1:0]  s1_phase_ff;
   // response stage
   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [SAMPLE_BITS-1:0] rsp_sample_in;
   // noise state
   logic [LFSR_BITS-1:0]   lfsr_ff;
   logic [LFSR_BITS-1:0]   lfsr_step;
   logic [LFSR_BITS-1:0]   lfsr_in;

   logic rsp_load;
   logic s1_advance;

   // pipeline flow control
   assign rsp_load   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && rsp_load;
   assign req_ready  = !s1_valid_ff || rsp_load;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff    <= req_op;
         s1_phase_ff <= req_phase;
      end
      if (s1_advance) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   // Galois LFSR: shift right, fold in taps when a one drops out
   assign lfsr_step = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : '0);

   always_comb begin
      lfsr_in = lfsr_ff;
      if (csr_valid && csr_ready) begin
         lfsr_in = (csr_noise_seed == '0) ? LFSR_RESET : csr_noise_seed;
      end else if (s1_advance && op_type'(s1_op_ff) == OP_NOISE) begin
         lfsr_in = lfsr_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_RESET;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   // sine: quadrant from the top address bits, mirrored quarter-table lookup
   logic [SINE_ADDR_BITS-1:0] sine_addr;
   logic [1:0]                sine_quad;
   logic [QBITS:0]            sine_idx;
   logic [SAMPLE_BITS-1:0]    sine_mag;
   logic [SAMPLE_BITS-1:0]    sine_value;

   assign sine_addr = s1_phase_ff[PHASE_BITS-1 -: SINE_ADDR_BITS];
   assign sine_quad = sine_addr[SINE_ADDR_BITS-1 -: 2];

   always_comb begin
      sine_idx = {1'b0, sine_addr[QBITS-1:0]};
      if (sine_quad[0]) begin
         sine_idx = (QBITS+1)'(QSIZE) - {1'b0, sine_addr[QBITS-1:0]};
      end
      // the quarter-turn point is full scale
      if (sine_idx[QBITS]) begin
         sine_mag = FULL_POS;
      end else begin
         sine_mag = SINE_QUARTER[sine_idx[QBITS-1:0]];
      end
      sine_value = sine_quad[1] ? (SAMPLE_BITS)'(-sine_mag) : sine_mag;
   end

   // triangle: rising half 2p - 32768, falling half 98304 - 2p, saturated at full scale
   logic signed [PHASE_BITS+1:0] tri_fall;
   logic [SAMPLE_BITS-1:0]       tri_value;

   assign tri_fall = 18'sd98304 - $signed({1'b0, s1_phase_ff, 1'b0});

   always_comb begin
      if (!s1_phase_ff[PHASE_BITS-1]) begin
         tri_value = {s1_phase_ff[PHASE_BITS-2:0], 1'b0} ^ FULL_NEG;
      end else if (tri_fall > 18'sd32767) begin
         tri_value = FULL_POS;
      end else begin
         tri_value = tri_fall[SAMPLE_BITS-1:0];
      end
   end

   // waveform select
   always_comb begin
      case (op_type'(s1_op_ff))
         OP_SQUARE:   rsp_sample_in = s1_phase_ff[PHASE_BITS-1] ? FULL_NEG : FULL_POS;
         OP_SAWTOOTH: rsp_sample_in = s1_phase_ff ^ FULL_NEG;
         OP_TRIANGLE: rsp_sample_in = tri_value;
         OP_NOISE:    rsp_sample_in = lfsr_step[LFSR_BITS-1 -: SAMPLE_BITS];
         default:     rsp_sample_in = sine_value;
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = $signed(rsp_sample_ff);

endmodule

FILE: hw/rtl/mws_checker.sv
// Port-level checker for the multi-waveform shaper, bound to the top level.
`timescale 1ns / 1ps

module mws_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [mws_pkg::SAMPLE_BITS-1:0] rsp_sample
);

   // once a taken request has passed the request register, a response is valid: its own or a stalled one still held
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("request taken but no response two cycles later");

   // with the response side open, the request side never stalls
   a_no_stall_open: assert property (@(posedge clock) disable iff (reset)
      rsp_ready || !rsp_valid |-> req_ready)
      else $error("request stalled while response side is open");

   // a stalled response holds its sample
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled response dropped or changed");

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind multi_waveform_shaper mws_checker u_mws_checker (.*);
